### rtl/bfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_pkg: shared types and constants of the bitmap font text renderer
// Field widths, command and character codes, register indexes, cursor type.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_WIDTH = 8;
    localparam int FONT_GLYPHS = 256;
    localparam int ROWS_OUT    = 16;
    localparam int LINE_STEP   = 16;

    localparam int FONT_AW     = 12;
    localparam int FONT_DW     = 8;
    localparam int ROW_W       = $clog2(ROWS_OUT);

    localparam int ADDR_W      = 48;
    localparam int DIM_W       = 14;
    localparam int COLOR_W     = 32;
    localparam int CODE_W      = 8;
    localparam int POS_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PRINT = 1'b1;

    localparam logic [CODE_W-1:0] CODE_NUL = 8'd0;
    localparam logic [CODE_W-1:0] CODE_TAB = 8'd9;
    localparam logic [CODE_W-1:0] CODE_NL  = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOUR    = 2'd3;

    localparam logic [ADDR_W-1:0]  RST_FRAME_BASE   = '0;
    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH = 14'd640;
    localparam logic [DIM_W-1:0]   RST_LINE_PITCH   = 14'd640;
    localparam logic [COLOR_W-1:0] RST_FG_COLOUR    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_cursor;

endpackage
`default_nettype wire

### rtl/bfr_font_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_font_mem: glyph store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bfr_font_mem
    import bfr_pkg::*;
#(
    parameter int AW = FONT_AW,
    parameter int DW = FONT_DW
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/bfr_cursor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_cursor: text cursor
// Advances, tabs, breaks lines and wraps the cursor for each printed code.
// ----------------------------------------------------------------------------
module bfr_cursor
    import bfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_print,
    input  wire logic [CODE_W-1:0] i_code,
    input  wire logic [DIM_W-1:0]  i_screen_width,
    output t_cursor                o_cursor
);

    t_cursor r_cursor;
    t_cursor n_cursor;

    function automatic logic [POS_W-1:0] f_move_down(input logic [POS_W-1:0] y);
        logic [POS_W:0] sum;
        sum = {1'b0, y} + (POS_W+1)'(LINE_STEP);
        f_move_down = sum[POS_W] ? '1 : sum[POS_W-1:0];
    endfunction

    always_comb begin
        t_cursor step;
        step = r_cursor;
        if (i_code == CODE_NL) begin
            step.x = '0;
            step.y = f_move_down(r_cursor.y);
        end else begin
            step.x = r_cursor.x + POS_W'(GLYPH_WIDTH);
        end
        if (({1'b0, step.x} + (POS_W+1)'(GLYPH_WIDTH)) > (POS_W+1)'(i_screen_width)) begin
            step.x = '0;
            step.y = f_move_down(step.y);
        end
        n_cursor = i_print ? step : r_cursor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else begin
            r_cursor <= n_cursor;
        end
    end

    assign o_cursor = r_cursor;

endmodule
`default_nettype wire

### rtl/bfr_row_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_row_seq: glyph row sequencer
// Reads sixteen glyph rows from the font store and emits one row write each.
// ----------------------------------------------------------------------------
module bfr_row_seq
    import bfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic [CODE_W-1:0]  i_code,
    input  wire t_cursor            i_cursor,
    input  wire logic [ADDR_W-1:0]  i_frame_base,
    input  wire logic [DIM_W-1:0]   i_line_pitch,
    input  wire logic [COLOR_W-1:0] i_fg_colour,
    output logic                    o_rd_en,
    output logic [FONT_AW-1:0]      o_rd_addr,
    output logic                    o_busy,
    output logic                    o_valid,
    output logic [ADDR_W-1:0]       o_write_addr,
    output logic [COLOR_W-1:0]      o_color,
    output logic                    o_last
);

    localparam int PIX_W = 32;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [PIX_W-1:0]    r_pix, n_pix;
    logic                r_valid, n_valid;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [COLOR_W-1:0]  r_color, n_color;
    logic                r_last, n_last;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_code  = r_code;
        n_pix   = r_pix;
        n_valid = 1'b0;
        n_addr  = r_addr;
        n_color = r_color;
        n_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_RUN;
                    n_row   = '0;
                    n_code  = i_code;
                    n_pix   = PIX_W'(i_cursor.y) * PIX_W'(i_line_pitch)
                              + PIX_W'(i_cursor.x);
                end
            end
            S_RUN: begin
                n_valid = 1'b1;
                n_addr  = i_frame_base + ADDR_W'({r_pix, 2'b00});
                n_color = i_fg_colour;
                n_last  = (r_row == ROW_W'(ROWS_OUT - 1));
                n_pix   = r_pix + PIX_W'(i_line_pitch);
                n_row   = r_row + 1'b1;
                if (n_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
        r_code  <= n_code;
        r_pix   <= n_pix;
        r_addr  <= n_addr;
        r_color <= n_color;
    end

    assign o_rd_en      = (r_state == S_RUN);
    assign o_rd_addr    = FONT_AW'(32'(r_code) * GLYPH_ROWS + 32'(r_row));
    assign o_busy       = (r_state == S_RUN) || r_valid;
    assign o_valid      = r_valid;
    assign o_write_addr = r_addr;
    assign o_color      = r_color;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    a_go_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> (r_state == S_IDLE && !r_valid))
        else $error("glyph request taken while rows still in flight");
    a_read_then_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |=> o_valid)
        else $error("font read without matching row write");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> (!o_valid && !o_busy))
        else $error("row writes continue after last row");
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last flag without row write");
`endif

endmodule
`default_nettype wire

### rtl/bitmap_font_text_renderer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer: 8x16 bitmap font text console
// Loads font bytes into the glyph store and turns printed characters into
// glyph row writes for a 32-bit-per-pixel framebuffer.
//
//   channel   handshake           payload
//   request   start / busy        i_command i_char_code i_font_index i_font_byte
//   result    o_valid (strobe)    o_write_addr o_pixel_mask o_color o_last
//   config    i_cfg_we            i_cfg_index i_cfg_data
//
// A glyph first registers its start pixel offset, then does one font store
// read per row, each row strobed in the cycle after its read. Load, tab,
// newline and code zero finish in the cycle they are taken. Reset
// (synchronous, active low) clears the cursor, registers and sequencer; the
// glyph store is not cleared.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer
    import bfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_command,
    input  wire logic [CODE_W-1:0]     i_char_code,
    input  wire logic [FONT_AW-1:0]    i_font_index,
    input  wire logic [FONT_DW-1:0]    i_font_byte,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic [ADDR_W-1:0]          o_write_addr,
    output logic [FONT_DW-1:0]         o_pixel_mask,
    output logic [COLOR_W-1:0]         o_color,
    output logic                       o_last
);

    logic [ADDR_W-1:0]  r_frame_base;
    logic [DIM_W-1:0]   r_screen_width;
    logic [DIM_W-1:0]   r_line_pitch;
    logic [COLOR_W-1:0] r_fg_colour;

    logic               accept;
    logic               load_we;
    logic               print;
    logic               glyph;
    logic               rd_en;
    logic [FONT_AW-1:0] rd_addr;
    t_cursor            cursor;

    assign accept  = start && !busy;
    assign load_we = accept && (i_command == CMD_LOAD);
    assign print   = accept && (i_command == CMD_PRINT) && (i_char_code != CODE_NUL);
    assign glyph   = print && (i_char_code != CODE_NL) && (i_char_code != CODE_TAB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base   <= RST_FRAME_BASE;
            r_screen_width <= RST_SCREEN_WIDTH;
            r_line_pitch   <= RST_LINE_PITCH;
            r_fg_colour    <= RST_FG_COLOUR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_BASE:   r_frame_base   <= i_cfg_data[ADDR_W-1:0];
                REG_SCREEN_WIDTH: r_screen_width <= i_cfg_data[DIM_W-1:0];
                REG_LINE_PITCH:   r_line_pitch   <= i_cfg_data[DIM_W-1:0];
                REG_FG_COLOUR:    r_fg_colour    <= i_cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bfr_font_mem #(
        .AW (FONT_AW),
        .DW (FONT_DW)
    ) u_font_mem (
        .i_clk     (i_clk),
        .i_wr_en   (load_we),
        .i_wr_addr (i_font_index),
        .i_wr_data (i_font_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (o_pixel_mask)
    );

    bfr_cursor u_cursor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_print        (print),
        .i_code         (i_char_code),
        .i_screen_width (r_screen_width),
        .o_cursor       (cursor)
    );

    bfr_row_seq u_row_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (glyph),
        .i_code       (i_char_code),
        .i_cursor     (cursor),
        .i_frame_base (r_frame_base),
        .i_line_pitch (r_line_pitch),
        .i_fg_colour  (r_fg_colour),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_write_addr (o_write_addr),
        .o_color      (o_color),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bitmap font text renderer
// Loads glyphs into the font store, prints characters under several register
// settings and sender idle rates, and checks every glyph row write against a
// predictor of the cursor, the font store and the address arithmetic. Covers
// line wrap, narrow screens and address wrap at the top of memory.
// ----------------------------------------------------------------------------
import bfr_pkg::*;

typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [FONT_DW-1:0] mask;
    logic [COLOR_W-1:0] color;
    logic               last;
} t_row_write;

class glyph_row_scoreboard;
    localparam int FONT_DEPTH  = 1 << FONT_AW;
    localparam int MAX_REPORTS = 40;

    logic [ADDR_W-1:0]  frame_base   = RST_FRAME_BASE;
    logic [DIM_W-1:0]   screen_width = RST_SCREEN_WIDTH;
    logic [DIM_W-1:0]   line_pitch   = RST_LINE_PITCH;
    logic [COLOR_W-1:0] fg_colour    = RST_FG_COLOUR;
    logic [FONT_DW-1:0] font_store [FONT_DEPTH];
    logic [POS_W-1:0]   cur_x = '0;
    logic [POS_W-1:0]   cur_y = '0;
    t_row_write         expected_rows [$];
    int                 failures = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_BASE:   frame_base   = data[ADDR_W-1:0];
            REG_SCREEN_WIDTH: screen_width = data[DIM_W-1:0];
            REG_LINE_PITCH:   line_pitch   = data[DIM_W-1:0];
            REG_FG_COLOUR:    fg_colour    = data[COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    function void step_down();
        if (cur_y > 16'hFFFF - LINE_STEP)
            cur_y = '1;
        else
            cur_y += LINE_STEP;
    endfunction

    function void note_request(logic cmd, logic [CODE_W-1:0] code,
                               logic [FONT_AW-1:0] idx, logic [FONT_DW-1:0] fbyte);
        t_row_write  row;
        logic [63:0] pix;
        int          glyph_base;
        if (cmd == CMD_LOAD) begin
            font_store[idx] = fbyte;
            return;
        end
        if (code == CODE_NUL)
            return;
        if (code == CODE_NL) begin
            cur_x = '0;
            step_down();
        end else if (code == CODE_TAB) begin
            cur_x += GLYPH_WIDTH;
        end else begin
            glyph_base = int'(code) * GLYPH_ROWS;
            for (int r = 0; r < ROWS_OUT; r++) begin
                pix       = 64'(cur_x) + (64'(cur_y) + 64'(r)) * 64'(line_pitch);
                pix       = pix << 2;
                row.addr  = frame_base + pix[ADDR_W-1:0];
                row.mask  = font_store[(glyph_base + r) & (FONT_DEPTH - 1)];
                row.color = fg_colour;
                row.last  = (r == ROWS_OUT - 1);
                expected_rows.push_back(row);
            end
            cur_x += GLYPH_WIDTH;
        end
        if (int'(cur_x) + GLYPH_WIDTH > int'(screen_width)) begin
            cur_x = '0;
            step_down();
        end
    endfunction

    function void flag_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
        failures++;
        if (failures <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
    endfunction

    function void check_row(logic [ADDR_W-1:0] addr, logic [FONT_DW-1:0] mask,
                            logic [COLOR_W-1:0] color, logic last);
        t_row_write exp_row;
        if (expected_rows.size() == 0) begin
            flag_field("o_valid", 64'd0, 64'd1);
            return;
        end
        exp_row = expected_rows.pop_front();
        if (addr !== exp_row.addr)
            flag_field("write_addr", 64'(exp_row.addr), 64'(addr));
        if (mask !== exp_row.mask)
            flag_field("pixel_mask", 64'(exp_row.mask), 64'(mask));
        if (color !== exp_row.color)
            flag_field("color", 64'(exp_row.color), 64'(color));
        if (last !== exp_row.last)
            flag_field("last", 64'(exp_row.last), 64'(last));
    endfunction

    function int pending();
        return expected_rows.size();
    endfunction
endclass

module testbench;
    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 8;
    localparam int SETTLE_CYCLES     = 24;
    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int PHASE_ITEMS       = 100;
    localparam int PHASE_COUNT       = 5;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic                  i_command    = CMD_LOAD;
    logic [CODE_W-1:0]     i_char_code  = '0;
    logic [FONT_AW-1:0]    i_font_index = '0;
    logic [FONT_DW-1:0]    i_font_byte  = '0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_valid;
    logic [ADDR_W-1:0]     o_write_addr;
    logic [FONT_DW-1:0]    o_pixel_mask;
    logic [COLOR_W-1:0]    o_color;
    logic                  o_last;

    glyph_row_scoreboard rows_sb = new();
    int                  idle_pct = 0;
    int                  cycle_count = 0;
    bit                  glyph_ready [256];
    logic [CODE_W-1:0]   ready_codes [$];

    bitmap_font_text_renderer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_font_index (i_font_index),
        .i_font_byte  (i_font_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_write_addr (o_write_addr),
        .o_pixel_mask (o_pixel_mask),
        .o_color      (o_color),
        .o_last       (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // check rows first, then note the request taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            rows_sb.check_row(o_write_addr, o_pixel_mask, o_color, o_last);
        if (i_rst_n && start && !busy)
            rows_sb.note_request(i_command, i_char_code, i_font_index, i_font_byte);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_request(input logic cmd, input logic [CODE_W-1:0] code,
                                input logic [FONT_AW-1:0] idx,
                                input logic [FONT_DW-1:0] fbyte);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_char_code  <= code;
        i_font_index <= idx;
        i_font_byte  <= fbyte;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_for_rows();
        start <= 1'b0;
        while (rows_sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        wait_for_rows();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        rows_sb.set_register(idx, data);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [DIM_W-1:0] width,
                             input logic [DIM_W-1:0] pitch, input logic [COLOR_W-1:0] color);
        write_register(REG_FRAME_BASE, CFG_DATA_W'(base));
        write_register(REG_SCREEN_WIDTH, CFG_DATA_W'(width));
        write_register(REG_LINE_PITCH, CFG_DATA_W'(pitch));
        write_register(REG_FG_COLOUR, CFG_DATA_W'(color));
        i_cfg_we <= 1'b0;
    endtask

    task automatic mark_ready(input logic [CODE_W-1:0] code);
        if (!glyph_ready[code]) begin
            glyph_ready[code] = 1'b1;
            ready_codes.push_back(code);
        end
    endtask

    task automatic load_glyph();
        logic [CODE_W-1:0]  code;
        logic [FONT_DW-1:0] fbyte;
        int                 pick;
        do code = CODE_W'($urandom_range(1, 255));
        while (code == CODE_TAB || code == CODE_NL);
        for (int r = 0; r < ROWS_OUT; r++) begin
            pick = $urandom_range(7);
            fbyte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : FONT_DW'($urandom);
            send_request(CMD_LOAD, CODE_W'($urandom), {code, ROW_W'(r)}, fbyte);
        end
        mark_ready(code);
    endtask

    task automatic run_directed();
        logic [FONT_DW-1:0] fbyte;
        send_request(CMD_LOAD, 8'hFF, '0, 8'h00);
        for (int r = 0; r < ROWS_OUT; r++) begin
            case (r)
                0:       fbyte = 8'h00;
                1:       fbyte = 8'hFF;
                2:       fbyte = 8'h80;
                3:       fbyte = 8'h01;
                default: fbyte = FONT_DW'($urandom);
            endcase
            send_request(CMD_LOAD, CODE_W'(r), {8'hFF, ROW_W'(r)}, fbyte);
        end
        mark_ready(8'hFF);
        send_request(CMD_PRINT, 8'hFF, '1, 8'hFF);
        send_request(CMD_PRINT, CODE_NUL, '0, '0);
        send_request(CMD_PRINT, CODE_TAB, '1, '0);
        send_request(CMD_PRINT, CODE_NL, '0, '1);
        send_request(CMD_PRINT, 8'hFF, '0, '0);
    endtask

    task automatic run_random(input int n_items);
        int                sent;
        int                pick;
        logic [CODE_W-1:0] code;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(39) == 0)
                wait_for_rows();
            pick = $urandom_range(99);
            if (pick < 12 || ready_codes.size() == 0) begin
                load_glyph();
                sent += ROWS_OUT;
            end else if (pick < 18) begin
                send_request(CMD_LOAD, CODE_W'($urandom), FONT_AW'($urandom),
                             FONT_DW'($urandom));
                sent++;
            end else if (pick < 24) begin
                send_request(CMD_PRINT, CODE_NL, FONT_AW'($urandom), FONT_DW'($urandom));
                sent++;
            end else if (pick < 30) begin
                send_request(CMD_PRINT, CODE_TAB, FONT_AW'($urandom), FONT_DW'($urandom));
                sent++;
            end else if (pick < 33) begin
                send_request(CMD_PRINT, CODE_NUL, FONT_AW'($urandom), FONT_DW'($urandom));
            end else begin
                code = ready_codes[$urandom_range(ready_codes.size() - 1)];
                send_request(CMD_PRINT, code, FONT_AW'($urandom), FONT_DW'($urandom));
                sent++;
            end
        end
    endtask

    task automatic configure_phase(input int phase);
        case (phase)
            1: begin
                idle_pct = 53;
                configure(48'hFFFF_FFFF_FFC0, 14'd8192, 14'd8192, 32'h0);
            end
            2: begin
                idle_pct = 38;
                configure('0, DIM_W'($urandom_range(0, 7)), '0, COLOR_W'($urandom));
            end
            3: begin
                idle_pct = 53;
                configure(ADDR_W'({$urandom, $urandom}), DIM_W'($urandom_range(0, 8192)),
                          DIM_W'($urandom_range(0, 8192)), COLOR_W'($urandom));
            end
            4: begin
                idle_pct = 38;
                configure(ADDR_W'({$urandom, $urandom}), DIM_W'($urandom_range(0, 8192)),
                          14'd8192, RST_FG_COLOUR);
            end
            default: idle_pct = 0;
        endcase
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            configure_phase(phase);
            run_random(PHASE_ITEMS);
        end
        settle();
        if (rows_sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
